/* rtl/sipf_pkg.sv */
package sipf_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam int QUEUE_DEPTH = 2;

	// byte position inside the framed packet
	typedef enum logic [2:0] {
		POS_SYNC0,
		POS_SYNC1,
		POS_ID,
		POS_LEN,
		POS_CMD,
		POS_PARAM,
		POS_CKS
	} pos_t;

	// what the back end must emit for one accepted item
	typedef struct packed {
		logic       hdr;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] cmd;
		logic       has_par;
		logic [7:0] par;
		logic       has_cks;
		logic [7:0] cks;
	} job_t;

endpackage

/* rtl/sipf_item_if.sv */
interface sipf_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] servo_id;
	logic [7:0] command;
	logic [7:0] param_count;
	logic [7:0] param_byte;

	modport source(output valid, output servo_id, output command, output param_count,
		output param_byte, input ready);
	modport sink(input valid, input servo_id, input command, input param_count,
		input param_byte, output ready);
endinterface

/* rtl/sipf_byte_if.sv */
interface sipf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       packet_end;

	modport source(output valid, output out_byte, output packet_end, input ready);
	modport sink(input valid, input out_byte, input packet_end, output ready);
endinterface

/* rtl/sipf_front.sv */
module sipf_front
	import sipf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sipf_item_if.sink    item,
	input  logic         q_full,
	output logic         push,
	output job_t         push_job
);

	logic       in_packet_q;
	logic [7:0] sum_q;
	logic [7:0] left_q;

	logic       first;
	logic [7:0] len;
	logic [7:0] hsum;
	logic [7:0] psum;
	logic [7:0] left;
	logic [7:0] left_n;
	logic       zero;

	assign item.ready = !q_full;
	assign push = item.valid && item.ready;

	always_comb begin
		first  = !in_packet_q;
		len    = item.param_count + 8'd2;
		hsum   = item.servo_id + len + item.command;
		psum   = (first ? hsum : sum_q) + item.param_byte;
		zero   = first && (item.param_count == 8'd0);
		left   = first ? item.param_count : left_q;
		left_n = left - 8'd1;

		push_job.hdr     = first;
		push_job.id      = item.servo_id;
		push_job.len     = len;
		push_job.cmd     = item.command;
		push_job.has_par = !zero;
		push_job.par     = item.param_byte;
		push_job.has_cks = zero || (left_n == 8'd0);
		push_job.cks     = zero ? ~hsum : ~psum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			sum_q       <= '0;
			left_q      <= '0;
		end else if (push && !zero) begin
			if (left_n == 8'd0) begin
				in_packet_q <= 1'b0;
				sum_q       <= '0;
				left_q      <= '0;
			end else begin
				in_packet_q <= 1'b1;
				sum_q       <= psum;
				left_q      <= left_n;
			end
		end
	end

endmodule

/* rtl/sipf_queue.sv */
module sipf_queue
	import sipf_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
)(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		bump = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

/* rtl/sipf_back.sv */
module sipf_back
	import sipf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  job_t         head_job,
	output logic         pop,
	sipf_byte_if.source  serial
);

	pos_t       pos_q;
	pos_t       pos_d;
	logic       busy_q;
	logic       busy_d;
	pos_t       cur;
	logic       emit;
	logic       last;
	logic [7:0] byte_d;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;

	assign emit = head_valid && (!valid_q || serial.ready);

	always_comb begin
		if (busy_q) begin
			cur = pos_q;
		end else if (head_job.hdr) begin
			cur = POS_SYNC0;
		end else if (head_job.has_par) begin
			cur = POS_PARAM;
		end else begin
			cur = POS_CKS;
		end

		last   = 1'b0;
		pos_d  = pos_q;
		byte_d = START_BYTE;
		case (cur)
			POS_SYNC0: begin
				byte_d = START_BYTE;
				pos_d  = POS_SYNC1;
			end
			POS_SYNC1: begin
				byte_d = START_BYTE;
				pos_d  = POS_ID;
			end
			POS_ID: begin
				byte_d = head_job.id;
				pos_d  = POS_LEN;
			end
			POS_LEN: begin
				byte_d = head_job.len;
				pos_d  = POS_CMD;
			end
			POS_CMD: begin
				byte_d = head_job.cmd;
				pos_d  = head_job.has_par ? POS_PARAM : POS_CKS;
			end
			POS_PARAM: begin
				byte_d = head_job.par;
				pos_d  = POS_CKS;
				last   = !head_job.has_cks;
			end
			POS_CKS: begin
				byte_d = head_job.cks;
				last   = 1'b1;
			end
			default: begin
				byte_d = START_BYTE;
				last   = 1'b1;
			end
		endcase

		busy_d = busy_q;
		if (emit) begin
			busy_d = !last;
		end
	end

	assign pop = emit && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_SYNC0;
			busy_q <= 1'b0;
		end else begin
			busy_q <= busy_d;
			if (emit) begin
				pos_q <= pos_d;
			end
		end
	end

	// output register: holds a beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || serial.ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_d;
			end_q  <= (cur == POS_CKS);
		end
	end

	assign serial.valid      = valid_q;
	assign serial.out_byte   = byte_q;
	assign serial.packet_end = end_q;

endmodule

/* rtl/servo_instruction_packet_framer.sv */
// Servo instruction packet framer.
// Channel item (sink): one beat per parameter byte. The first beat of a
// packet also carries servo_id, command and param_count; those fields are
// ignored on later beats. A packet with param_count zero takes one beat
// whose param_byte is ignored.
// Channel serial (source): one framed byte per beat, packet_end high on the
// closing checksum byte. A first item yields the header 0xFF 0xFF id len cmd,
// then its parameter if any, then the checksum if it was the last: up to seven
// beats. Later items yield one or two beats.
// An accepted item passes through the job queue, then the output register,
// before its first beat is valid. Throughput: one output beat per cycle
// while serial is ready, set by the single-byte serializer at the back end.
// Items are accepted while the job queue between front and back has room,
// so the front keeps taking items while the back is still sending.
// Reset: no packet open, queue empty, no output beat pending.
// When serial stalls, the current beat is held and the queue fills; item
// ready drops once the queue is full.
module servo_instruction_packet_framer
	import sipf_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
)(
	input  logic        clk,
	input  logic        arst_n,
	sipf_item_if.sink   item,
	sipf_byte_if.source serial
);

	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_job;

	sipf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (full),
		.push     (push),
		.push_job (push_job)
	);

	sipf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sipf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.serial     (serial)
	);

endmodule
